// File: src/mtq_pkg.sv
// ----------------------------------------------------------------------------
// mtq_pkg
// Shared types and constants for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package mtq_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int SQRT_STAGES = 8;   // two root iterations per stage
  localparam int DIV_STAGES  = 8;   // two quotient bits per stage
  localparam int LATENCY     = SQRT_STAGES + DIV_STAGES + 2;

  localparam logic [31:0] SQRT_BIT0 = 32'h4000_0000;

  typedef struct packed {
    logic             pos;
    logic [1:0]       idx;
    logic [2:0][17:0] d;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] n;
    logic [31:0] res;
    logic [31:0] rbit;
  } sqrt_t;

  typedef struct packed {
    side_t            side;
    logic [15:0]      s;
    logic [31:0]      dsh;
    logic [2:0][31:0] rem;
    logic [2:0][15:0] quo;
  } div_t;

endpackage

// File: src/mtq_decode.sv
// ----------------------------------------------------------------------------
// mtq_decode
// Trace test, pivot selection, root argument and numerator setup.
// ----------------------------------------------------------------------------
module mtq_decode import mtq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_req,
  input  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic               valid_r,
  output sqrt_t              data_r
);

  localparam logic signed [18:0] ONE = 19'sd1 <<< FRAC_BITS;

  function automatic logic signed [18:0] sx(input logic signed [15:0] v);
    sx = 19'(v);
  endfunction

  logic signed [18:0] trace, arg, arg_c;
  logic [1:0]         idx;
  side_t              side;
  sqrt_t              data_nxt;

  always_comb begin
    trace = sx(m00) + sx(m11) + sx(m22);
    idx = 2'd0;
    if (m11 > m00) idx = 2'd1;
    if (m22 > ((idx == 2'd1) ? m11 : m00)) idx = 2'd2;
    side.pos = trace > 19'sd0;
    side.idx = idx;
    if (side.pos) begin
      arg       = trace + ONE;
      side.d[0] = 18'(sx(m21) - sx(m12));
      side.d[1] = 18'(sx(m02) - sx(m20));
      side.d[2] = 18'(sx(m10) - sx(m01));
    end else begin
      case (idx)
        2'd1: begin
          arg       = sx(m11) - sx(m22) - sx(m00) + ONE;
          side.d[0] = 18'(sx(m02) - sx(m20));
          side.d[1] = 18'(sx(m21) + sx(m12));
          side.d[2] = 18'(sx(m01) + sx(m10));
        end
        2'd2: begin
          arg       = sx(m22) - sx(m00) - sx(m11) + ONE;
          side.d[0] = 18'(sx(m10) - sx(m01));
          side.d[1] = 18'(sx(m02) + sx(m20));
          side.d[2] = 18'(sx(m12) + sx(m21));
        end
        default: begin
          arg       = sx(m00) - sx(m11) - sx(m22) + ONE;
          side.d[0] = 18'(sx(m21) - sx(m12));
          side.d[1] = 18'(sx(m10) + sx(m01));
          side.d[2] = 18'(sx(m20) + sx(m02));
        end
      endcase
    end
    arg_c         = (arg < 19'sd0) ? 19'sd0 : arg;
    data_nxt.side = side;
    data_nxt.n    = {1'b0, arg_c[16:0], 14'd0};
    data_nxt.res  = 32'd0;
    data_nxt.rbit = SQRT_BIT0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= in_req;
    data_r <= data_nxt;
  end

endmodule

// File: src/mtq_sqrt_stage.sv
// ----------------------------------------------------------------------------
// mtq_sqrt_stage
// Two iterations of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module mtq_sqrt_stage import mtq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  input  sqrt_t data_i,
  output logic  valid_r,
  output sqrt_t data_r
);

  sqrt_t a, b;

  function automatic sqrt_t iter(input sqrt_t v);
    sqrt_t o;
    o = v;
    if (v.n >= v.res + v.rbit) begin
      o.n   = v.n - (v.res + v.rbit);
      o.res = (v.res >> 1) + v.rbit;
    end else begin
      o.res = v.res >> 1;
    end
    o.rbit = v.rbit >> 2;
    iter = o;
  endfunction

  always_comb begin
    a = iter(data_i);
    b = iter(a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_i;
    data_r <= b;
  end

endmodule

// File: src/mtq_div_stage.sv
// ----------------------------------------------------------------------------
// mtq_div_stage
// Two restoring division steps on the three numerator lanes.
// ----------------------------------------------------------------------------
module mtq_div_stage import mtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_r,
  output div_t data_r
);

  div_t a, b;

  function automatic div_t step(input div_t v);
    div_t o;
    o = v;
    for (int l = 0; l < 3; l++) begin
      if (v.rem[l] >= v.dsh) begin
        o.rem[l] = v.rem[l] - v.dsh;
        o.quo[l] = {v.quo[l][14:0], 1'b1};
      end else begin
        o.quo[l] = {v.quo[l][14:0], 1'b0};
      end
    end
    o.dsh = v.dsh >> 1;
    step = o;
  endfunction

  always_comb begin
    a = step(data_i);
    b = step(a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_i;
    data_r <= b;
  end

endmodule

// File: src/mtq_pack.sv
// ----------------------------------------------------------------------------
// mtq_pack
// Sign restore, saturation and component placement; output register.
// ----------------------------------------------------------------------------
module mtq_pack import mtq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  div_t               data_i,
  output logic               valid_r,
  output logic signed [15:0] q_w_r,
  output logic signed [15:0] q_x_r,
  output logic signed [15:0] q_y_r,
  output logic signed [15:0] q_z_r
);

  logic [2:0][15:0] lane;
  logic [15:0]      half;
  logic [3:0][15:0] q_nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (data_i.s == 16'd0)       lane[l] = 16'd0;
      else if (data_i.side.d[l][17]) begin
        lane[l] = data_i.quo[l][15] ? 16'h8000 : 16'(-data_i.quo[l]);
      end else begin
        lane[l] = data_i.quo[l][15] ? 16'h7fff : data_i.quo[l];
      end
    end
    half = data_i.s >> 1;
    if (data_i.side.pos) begin
      q_nxt = {lane[2], lane[1], lane[0], half};
    end else begin
      case (data_i.side.idx)
        2'd1:    q_nxt = {lane[1], half, lane[2], lane[0]};
        2'd2:    q_nxt = {half, lane[2], lane[1], lane[0]};
        default: q_nxt = {lane[2], lane[1], half, lane[0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_i;
    q_w_r <= q_nxt[0];
    q_x_r <= q_nxt[1];
    q_y_r <= q_nxt[2];
    q_z_r <= q_nxt[3];
  end

endmodule

// File: src/matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// matrix_to_quaternion
// Rotation matrix (Q2.14) to quaternion (Q2.14), Shepperd's method.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine elements on in_m* and raise start; the request is taken
//   at any edge with start high and busy low. busy is always low: the
//   pipeline takes one matrix every cycle.
//   Each result appears on out_q_* for one cycle with out_valid high, in
//   request order.
//   Latency: 1 decode stage, 8 root stages (two iterations each),
//   8 divide stages (two quotient bits each), 1 output stage.
//   Throughput: one matrix per cycle.
//   Reset clears all stage valid bits; requests in flight are dropped.
//   The receiver cannot stall; results must be taken when shown.
// ----------------------------------------------------------------------------
module matrix_to_quaternion import mtq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_m00, in_m01, in_m02,
  input  logic signed [15:0] in_m10, in_m11, in_m12,
  input  logic signed [15:0] in_m20, in_m21, in_m22,
  output logic               out_valid,
  output logic signed [15:0] out_q_w,
  output logic signed [15:0] out_q_x,
  output logic signed [15:0] out_q_y,
  output logic signed [15:0] out_q_z
);

  logic  sq_v [SQRT_STAGES+1];
  sqrt_t sq_d [SQRT_STAGES+1];
  logic  dv_v [DIV_STAGES+1];
  div_t  dv_d [DIV_STAGES+1];

  assign busy = 1'b0;

  mtq_decode u_decode (
    .clk, .rst_n, .in_req(start && !busy),
    .m00(in_m00), .m01(in_m01), .m02(in_m02),
    .m10(in_m10), .m11(in_m11), .m12(in_m12),
    .m20(in_m20), .m21(in_m21), .m22(in_m22),
    .valid_r(sq_v[0]), .data_r(sq_d[0])
  );

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    mtq_sqrt_stage u_st (
      .clk, .rst_n, .valid_i(sq_v[g]), .data_i(sq_d[g]),
      .valid_r(sq_v[g+1]), .data_r(sq_d[g+1])
    );
  end

  // divisor 2s aligned to quotient bit 15; numerator |d|<<14 plus s for rounding
  always_comb begin
    logic [15:0] s;
    logic [16:0] mag;
    s = sq_d[SQRT_STAGES].res[15:0];
    dv_v[0]      = sq_v[SQRT_STAGES];
    dv_d[0].side = sq_d[SQRT_STAGES].side;
    dv_d[0].s    = s;
    dv_d[0].dsh  = {s, 16'd0};
    for (int l = 0; l < 3; l++) begin
      mag = sq_d[SQRT_STAGES].side.d[l][17] ? 17'(-sq_d[SQRT_STAGES].side.d[l])
                                             : sq_d[SQRT_STAGES].side.d[l][16:0];
      dv_d[0].rem[l] = {1'b0, mag, 14'd0} + {16'd0, s};
      dv_d[0].quo[l] = 16'd0;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    mtq_div_stage u_st (
      .clk, .rst_n, .valid_i(dv_v[g]), .data_i(dv_d[g]),
      .valid_r(dv_v[g+1]), .data_r(dv_d[g+1])
    );
  end

  mtq_pack u_pack (
    .clk, .rst_n, .valid_i(dv_v[DIV_STAGES]), .data_i(dv_d[DIV_STAGES]),
    .valid_r(out_valid),
    .q_w_r(out_q_w), .q_x_r(out_q_x), .q_y_r(out_q_y), .q_z_r(out_q_z)
  );

endmodule

// File: src/mtq_checker.sv
// ----------------------------------------------------------------------------
// mtq_checker
// Port-level checks for matrix_to_quaternion.
// ----------------------------------------------------------------------------
module mtq_checker import mtq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_m00, in_m01, in_m02,
  input logic signed [15:0] in_m10, in_m11, in_m12,
  input logic signed [15:0] in_m20, in_m21, in_m22,
  input logic               out_valid,
  input logic signed [15:0] out_q_w,
  input logic signed [15:0] out_q_x,
  input logic signed [15:0] out_q_y,
  input logic signed [15:0] out_q_z
);

  logic zero_in;
  assign zero_in = (in_m00 == 16'sd0) && (in_m01 == 16'sd0) && (in_m02 == 16'sd0) &&
                   (in_m10 == 16'sd0) && (in_m11 == 16'sd0) && (in_m12 == 16'sd0) &&
                   (in_m20 == 16'sd0) && (in_m21 == 16'sd0) && (in_m22 == 16'sd0);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("request produced no result");

  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without request");

  a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && zero_in |-> ##LATENCY
      (out_q_w == 16'sd0) && (out_q_x == 16'sd8192) &&
      (out_q_y == 16'sd0) && (out_q_z == 16'sd0))
    else $error("zero matrix result wrong");

endmodule

bind matrix_to_quaternion mtq_checker u_mtq_checker (.*);

// File: bench/tb_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// tb_matrix_to_quaternion
// Self-checking bench for the matrix to quaternion pipeline. A queue of
// matrices feeds a clocked driver; each accepted request is converted by a
// local fixed-point Shepperd model and the monitor compares every strobed
// quaternion against the oldest prediction. Directed corner cases are
// followed by random near-rotation and raw matrices over idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_to_quaternion;
  import mtq_pkg::*;

  typedef struct packed {
    logic signed [0:2][0:2][15:0] m;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  localparam int WATCHDOG = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_m00 = '0, in_m01 = '0, in_m02 = '0;
  logic signed [15:0] in_m10 = '0, in_m11 = '0, in_m12 = '0;
  logic signed [15:0] in_m20 = '0, in_m21 = '0, in_m22 = '0;
  logic out_valid;
  logic signed [15:0] out_q_w, out_q_x, out_q_y, out_q_z;

  mat_t  pending_mats[$];
  quat_t expected_quats[$];
  mat_t  cur_mat;
  int    idle_pct = 0;
  int    errors = 0;
  int    quiet_cycles = 0;
  bit    stim_done = 0;

  matrix_to_quaternion dut (
    .clk, .rst_n, .start, .busy,
    .in_m00, .in_m01, .in_m02, .in_m10, .in_m11, .in_m12,
    .in_m20, .in_m21, .in_m22,
    .out_valid, .out_q_w, .out_q_x, .out_q_y, .out_q_z
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint div_by_2s(longint d, longint unsigned s);
    longint unsigned mag, q;
    if (s == 0) return 0;
    mag = (d < 0) ? -d : d;
    q = ((mag << FRAC_BITS) + s) / (2 * s);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic quat_t shepperd(mat_t a);
    longint m[3][3];
    longint q[4];
    longint tr, arg, one;
    longint unsigned s;
    int i, j, k;
    quat_t r;
    one = 64'sd1 << FRAC_BITS;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        m[rr][cc] = longint'(signed'(a.m[rr][cc]));
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      s = int_sqrt(longint'(tr + one) << FRAC_BITS);
      q[0] = s >> 1;
      q[1] = div_by_2s(m[2][1] - m[1][2], s);
      q[2] = div_by_2s(m[0][2] - m[2][0], s);
      q[3] = div_by_2s(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = m[i][i] - (m[j][j] + m[k][k]) + one;
      if (arg < 0) arg = 0;
      s = int_sqrt(arg << FRAC_BITS);
      q[0] = div_by_2s(m[k][j] - m[j][k], s);
      q[1 + i] = s >> 1;
      q[1 + j] = div_by_2s(m[j][i] + m[i][j], s);
      q[1 + k] = div_by_2s(m[k][i] + m[i][k], s);
    end
    r.w = sat16(q[0]);
    r.x = sat16(q[1]);
    r.y = sat16(q[2]);
    r.z = sat16(q[3]);
    return r;
  endfunction

  function automatic mat_t diag_mat(int d0, int d1, int d2, int off);
    mat_t a;
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++)
        a.m[rr][cc] = (rr == cc) ? 16'(d0 * (rr == 0) + d1 * (rr == 1) + d2 * (rr == 2))
                                 : 16'(off * (rr + 1) - cc * 17);
    return a;
  endfunction

  // Random matrix: raw bits, small off-diagonal, or all elements in [-1, 1].
  function automatic mat_t rand_mat();
    mat_t a;
    int mode;
    mode = $urandom_range(0, 9);
    for (int rr = 0; rr < 3; rr++)
      for (int cc = 0; cc < 3; cc++) begin
        if (mode < 3)
          a.m[rr][cc] = 16'($urandom);
        else if (mode < 5)
          a.m[rr][cc] = (rr == cc) ? 16'($urandom_range(0, 2) * 16384 - 16384) :
                                     16'($urandom_range(0, 4096) - 2048);
        else
          a.m[rr][cc] = 16'($urandom_range(0, 32768) - 16384);
      end
    return a;
  endfunction

  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      void'(pending_mats.pop_front());
    end
    if (rst_n && pending_mats.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
      cur_mat = pending_mats[0];
      {in_m00, in_m01, in_m02} <= cur_mat.m[0];
      {in_m10, in_m11, in_m12} <= cur_mat.m[1];
      {in_m20, in_m21, in_m22} <= cur_mat.m[2];
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    quat_t e;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else                               quiet_cycles <= quiet_cycles + 1;
      if (start && !busy) begin
        expected_quats.push_back(shepperd({in_m00, in_m01, in_m02, in_m10, in_m11,
                                           in_m12, in_m20, in_m21, in_m22}));
      end
      if (out_valid) begin
        if (expected_quats.size() == 0) begin
          $error("unexpected result w=%0d x=%0d y=%0d z=%0d",
                 out_q_w, out_q_x, out_q_y, out_q_z);
          errors++;
        end else begin
          e = expected_quats.pop_front();
          if (out_q_w !== e.w) begin
            $error("q_w expected %0d got %0d", e.w, out_q_w); errors++;
          end
          if (out_q_x !== e.x) begin
            $error("q_x expected %0d got %0d", e.x, out_q_x); errors++;
          end
          if (out_q_y !== e.y) begin
            $error("q_y expected %0d got %0d", e.y, out_q_y); errors++;
          end
          if (out_q_z !== e.z) begin
            $error("q_z expected %0d got %0d", e.z, out_q_z); errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("FAIL matrix_to_quaternion");
        $finish;
      end
    end
  end

  initial begin
    mat_t a;
    int phase_pct[4] = '{0, 67, 67, 6};
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // identity, zero, extremes, each branch winner, ties
    pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
    pending_mats.push_back(diag_mat(0, 0, 0, 0));
    pending_mats.push_back(diag_mat(32767, 32767, 32767, 300));
    pending_mats.push_back(diag_mat(-32768, -32768, -32768, 0));
    pending_mats.push_back(diag_mat(16384, -16384, -16384, 100));
    pending_mats.push_back(diag_mat(-16384, 16384, -16384, 100));
    pending_mats.push_back(diag_mat(-16384, -16384, 16384, 100));
    pending_mats.push_back(diag_mat(-8000, -8000, -8000, 50));
    pending_mats.push_back(diag_mat(-5, -5, 10, 0));
    pending_mats.push_back(diag_mat(0, 0, -1, 700));
    pending_mats.push_back(diag_mat(-32768, 32767, 32767, 2000));
    pending_mats.push_back(diag_mat(1, 0, -1, 3));
    pending_mats.push_back(diag_mat(-1, -1, -1, 20000));
    for (int b = 0; b < 2; b++) begin
      for (int rr = 0; rr < 3; rr++)
        for (int cc = 0; cc < 3; cc++)
          a.m[rr][cc] = b ? 16'sh7fff : 16'sh8000;
      pending_mats.push_back(a);
    end
    for (int b = 0; b < 2; b++) begin
      for (int rr = 0; rr < 3; rr++)
        for (int cc = 0; cc < 3; cc++)
          a.m[rr][cc] = (rr == cc) ? 16'sh8000 : (b ? 16'sh7fff : 16'sh8000);
      pending_mats.push_back(a);
    end
    wait (pending_mats.size() == 0);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int n = 0; n < 325; n++) pending_mats.push_back(rand_mat());
      wait (pending_mats.size() == 0);
    end

    wait (expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("PASS matrix_to_quaternion");
    end else begin
      $display("FAIL matrix_to_quaternion");
    end
    $finish;
  end

endmodule
